@@ src/linked_list_deque_manager_defines.svh @@
// assertion macros for the linked list deque manager
`ifndef LINKED_LIST_DEQUE_MANAGER_DEFINES_SVH
`define LINKED_LIST_DEQUE_MANAGER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LLDM_CHECK(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LLDM_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/lldm_pkg.sv @@
// shared constants, types and helpers for the linked list deque manager
`timescale 1ns / 1ps

package lldm_pkg;

  localparam int NODES   = 64;
  localparam int IDX_W   = $clog2(NODES);
  localparam int LINK_W  = $clog2(NODES + 1);
  localparam int COUNT_W = 7;

  typedef logic [LINK_W-1:0] ptr_t;

  localparam ptr_t NONE_PTR = ptr_t'(NODES);
  localparam ptr_t STEP_MAX = ptr_t'(NODES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_PUSH_TAIL = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_POP_TAIL  = 3'd4,
    OP_REMOVE    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_t;

  // link values past the end read as none
  function automatic ptr_t link_fix(input ptr_t v);
    return (v > NONE_PTR) ? NONE_PTR : v;
  endfunction

endpackage

@@ src/lldm_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module lldm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/linked_list_deque_manager.sv @@
// top level of the linked list deque manager: doubly linked list over a node pool
// one beat in at a time; clear and ignored ops end in idle, push in the push state,
// pop in pop then clear states; remove walks from the head via check and step states,
// at most NODES steps with one next-link ram read each, then remove and clear states;
// a result waits in the output register and the next op starts only after it is loaded
// synchronous reset empties the list; link rams are not cleared
`timescale 1ns / 1ps

`include "linked_list_deque_manager_defines.svh"

module linked_list_deque_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op[2:0], node_index[8:3], zero[15:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // popped_node[5:0], status[7:6], node_count[14:8], is_empty[15]
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_PUSH  = 8'b00000010,
    ST_POP   = 8'b00000100,
    ST_WCHK  = 8'b00001000,
    ST_WSTEP = 8'b00010000,
    ST_RMV   = 8'b00100000,
    ST_CLRC  = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_t;

  state_t state, state_next;

  lldm_pkg::ptr_t head, head_next;
  lldm_pkg::ptr_t tail, tail_next;
  lldm_pkg::ptr_t cur, cur_next;
  lldm_pkg::ptr_t steps, steps_next;
  lldm_pkg::ptr_t node_r, node_r_next;
  logic           node_ok, node_ok_next;
  lldm_pkg::op_t  op_r, op_r_next;
  logic [lldm_pkg::COUNT_W-1:0] count, count_next;
  logic [5:0]        popped, popped_next;
  lldm_pkg::status_t status_r, status_next;

  logic [5:0]                   out_popped;
  lldm_pkg::status_t            out_status;
  logic [lldm_pkg::COUNT_W-1:0] out_count;
  logic                         out_empty;
  logic                         m_tvalid_next;
  logic                         out_load;
  logic                         out_free;
  logic                         finish;
  logic                         count_up;
  logic                         count_down;

  lldm_pkg::op_t  in_op;
  logic [5:0]     in_node;
  logic           in_ok;
  lldm_pkg::ptr_t in_ptr;

  logic                       nx_we, pv_we;
  logic [lldm_pkg::IDX_W-1:0] nx_waddr, pv_waddr, nx_raddr, pv_raddr;
  lldm_pkg::ptr_t             nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  lldm_pkg::ptr_t             nx_link, pv_link;

  lldm_ram #(.DEPTH(lldm_pkg::NODES), .WIDTH(lldm_pkg::LINK_W)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  lldm_ram #(.DEPTH(lldm_pkg::NODES), .WIDTH(lldm_pkg::LINK_W)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  assign in_op    = lldm_pkg::op_t'(s_tdata[2:0]);
  assign in_node  = s_tdata[8:3];
  assign in_ok    = (32'(in_node) < lldm_pkg::NODES);
  assign in_ptr   = lldm_pkg::ptr_t'(in_node);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign nx_link  = lldm_pkg::link_fix(nx_rdata);
  assign pv_link  = lldm_pkg::link_fix(pv_rdata);

  // idle reads the ends of the list, the other states read the current node
  assign nx_raddr = (state == ST_IDLE) ? head[lldm_pkg::IDX_W-1:0] : cur[lldm_pkg::IDX_W-1:0];
  assign pv_raddr = (state == ST_IDLE) ? tail[lldm_pkg::IDX_W-1:0] : cur[lldm_pkg::IDX_W-1:0];

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    cur_next     = cur;
    steps_next   = steps;
    node_r_next  = node_r;
    node_ok_next = node_ok;
    op_r_next    = op_r;
    popped_next  = popped;
    status_next  = status_r;
    finish       = 1'b0;
    count_up     = 1'b0;
    count_down   = 1'b0;
    nx_we        = 1'b0;
    nx_waddr     = cur[lldm_pkg::IDX_W-1:0];
    nx_wdata     = lldm_pkg::NONE_PTR;
    pv_we        = 1'b0;
    pv_waddr     = cur[lldm_pkg::IDX_W-1:0];
    pv_wdata     = lldm_pkg::NONE_PTR;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_r_next    = in_op;
          node_r_next  = in_ptr;
          node_ok_next = in_ok;
          popped_next  = 6'd0;
          status_next  = lldm_pkg::STAT_OK;
          unique case (in_op)
            lldm_pkg::OP_CLEAR: begin
              head_next = lldm_pkg::NONE_PTR;
              tail_next = lldm_pkg::NONE_PTR;
              finish    = 1'b1;
            end
            lldm_pkg::OP_PUSH_HEAD: begin
              if (in_ok) begin
                nx_we      = 1'b1;
                nx_waddr   = in_ptr[lldm_pkg::IDX_W-1:0];
                nx_wdata   = head;
                pv_we      = 1'b1;
                pv_waddr   = in_ptr[lldm_pkg::IDX_W-1:0];
                state_next = ST_PUSH;
              end else begin
                finish = 1'b1;
              end
            end
            lldm_pkg::OP_PUSH_TAIL: begin
              if (in_ok) begin
                pv_we      = 1'b1;
                pv_waddr   = in_ptr[lldm_pkg::IDX_W-1:0];
                pv_wdata   = tail;
                nx_we      = 1'b1;
                nx_waddr   = in_ptr[lldm_pkg::IDX_W-1:0];
                state_next = ST_PUSH;
              end else begin
                finish = 1'b1;
              end
            end
            lldm_pkg::OP_POP_HEAD: begin
              if (head == lldm_pkg::NONE_PTR) begin
                status_next = lldm_pkg::STAT_EMPTY;
                finish      = 1'b1;
              end else begin
                cur_next   = head;
                state_next = ST_POP;
              end
            end
            lldm_pkg::OP_POP_TAIL: begin
              if (tail == lldm_pkg::NONE_PTR) begin
                status_next = lldm_pkg::STAT_EMPTY;
                finish      = 1'b1;
              end else begin
                cur_next   = tail;
                state_next = ST_POP;
              end
            end
            lldm_pkg::OP_REMOVE: begin
              cur_next   = head;
              steps_next = '0;
              state_next = ST_WCHK;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      ST_PUSH: begin
        count_up = 1'b1;
        finish   = 1'b1;
        if (op_r == lldm_pkg::OP_PUSH_HEAD) begin
          if (head != lldm_pkg::NONE_PTR) begin
            pv_we    = 1'b1;
            pv_waddr = head[lldm_pkg::IDX_W-1:0];
            pv_wdata = node_r;
          end else begin
            tail_next = node_r;
          end
          head_next = node_r;
        end else begin
          if (tail != lldm_pkg::NONE_PTR) begin
            nx_we    = 1'b1;
            nx_waddr = tail[lldm_pkg::IDX_W-1:0];
            nx_wdata = node_r;
          end else begin
            head_next = node_r;
          end
          tail_next = node_r;
        end
      end

      ST_POP: begin
        popped_next = 6'(cur);
        state_next  = ST_CLRC;
        if (op_r == lldm_pkg::OP_POP_HEAD) begin
          head_next = nx_link;
          if (nx_link == lldm_pkg::NONE_PTR) begin
            tail_next = lldm_pkg::NONE_PTR;
          end else begin
            pv_we    = 1'b1;
            pv_waddr = nx_link[lldm_pkg::IDX_W-1:0];
          end
          nx_we = 1'b1;
        end else begin
          tail_next = pv_link;
          if (pv_link == lldm_pkg::NONE_PTR) begin
            head_next = lldm_pkg::NONE_PTR;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = pv_link[lldm_pkg::IDX_W-1:0];
          end
          pv_we = 1'b1;
        end
      end

      ST_WCHK: begin
        if (cur == lldm_pkg::NONE_PTR) begin
          status_next = lldm_pkg::STAT_NOTFOUND;
          finish      = 1'b1;
        end else if (node_ok && (cur == node_r)) begin
          state_next = ST_RMV;
        end else if (steps == lldm_pkg::STEP_MAX) begin
          status_next = lldm_pkg::STAT_NOTFOUND;
          finish      = 1'b1;
        end else begin
          state_next = ST_WSTEP;
        end
      end

      ST_WSTEP: begin
        cur_next   = nx_link;
        steps_next = steps + 1'b1;
        state_next = ST_WCHK;
      end

      ST_RMV: begin
        state_next = ST_CLRC;
        if (pv_link != lldm_pkg::NONE_PTR) begin
          nx_we    = 1'b1;
          nx_waddr = pv_link[lldm_pkg::IDX_W-1:0];
          nx_wdata = nx_link;
        end else begin
          head_next = nx_link;
        end
        if (nx_link != lldm_pkg::NONE_PTR) begin
          pv_we    = 1'b1;
          pv_waddr = nx_link[lldm_pkg::IDX_W-1:0];
          pv_wdata = pv_link;
        end else begin
          tail_next = pv_link;
        end
      end

      ST_CLRC: begin
        nx_we      = 1'b1;
        pv_we      = 1'b1;
        count_down = 1'b1;
        finish     = 1'b1;
      end

      ST_FIN: begin
        finish = 1'b1;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    count_next = count;
    if ((state == ST_IDLE) && s_tvalid && (in_op == lldm_pkg::OP_CLEAR)) begin
      count_next = '0;
    end else if (count_up && (count < lldm_pkg::COUNT_MAX)) begin
      count_next = count + 1'b1;
    end else if (count_down && (count != '0)) begin
      count_next = count - 1'b1;
    end

    out_load = 1'b0;
    if (finish) begin
      if (out_free) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        state_next = ST_FIN;
      end
    end

    m_tvalid_next = m_tvalid && !m_tready;
    if (out_load) begin
      m_tvalid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= lldm_pkg::NONE_PTR;
      tail     <= lldm_pkg::NONE_PTR;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    steps    <= steps_next;
    node_r   <= node_r_next;
    node_ok  <= node_ok_next;
    op_r     <= op_r_next;
    popped   <= popped_next;
    status_r <= status_next;
    if (out_load) begin
      out_popped <= popped_next;
      out_status <= status_next;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
    end
  end

  assign m_tdata = {out_empty, out_count, out_status, out_popped};

  `LLDM_CHECK(a_empty_flag, m_tvalid, out_empty == (out_count == '0), "empty flag disagrees with count")
  `LLDM_CHECK(a_popped_ok, m_tvalid && (out_status != lldm_pkg::STAT_OK), out_popped == 6'd0, "node reported on failed op")
  `LLDM_CHECK(a_walk_bound, state == ST_WCHK, steps <= lldm_pkg::STEP_MAX, "remove walk ran past the pool size")
  `LLDM_CHECK_NEXT(a_push_count, state == ST_PUSH, count != '0, "count zero after push")

endmodule
